// ===== rtl/core/rbpi_pkg.sv =====
// Shared definitions for the rigid body pose integrator.
// Holds the controller-to-datapath command and status types, micro-op codes
// and the fixed-point constants. Depends on nothing.
package rbpi_pkg;

    localparam int POS_BITS_DEF   = 32;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int DIV_W    = 32;
    localparam int DIV_CNTW = $clog2(DIV_W);

    localparam logic [15:0] POLY_A  = 16'd51438;
    localparam logic [15:0] POLY_B  = 16'd20956;
    localparam logic [15:0] POLY_C  = 16'd2286;
    localparam logic [14:0] COS_MIN = 15'd64;

    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_CAPTURE  = 4'd1;
    localparam logic [3:0] CMD_LOAD     = 4'd2;
    localparam logic [3:0] CMD_SIN      = 4'd3;
    localparam logic [3:0] CMD_MUL      = 4'd4;
    localparam logic [3:0] CMD_DIV_INIT = 4'd5;
    localparam logic [3:0] CMD_DIV_STEP = 4'd6;
    localparam logic [3:0] CMD_DIV_DONE = 4'd7;
    localparam logic [3:0] CMD_UPDATE   = 4'd8;
    localparam logic [3:0] CMD_FOLD     = 4'd9;
    localparam logic [3:0] CMD_EMIT     = 4'd10;

    localparam logic [4:0] TRIG_SR   = 5'd0;
    localparam logic [4:0] TRIG_CR   = 5'd1;
    localparam logic [4:0] TRIG_SP   = 5'd2;
    localparam logic [4:0] TRIG_CP   = 5'd3;
    localparam logic [4:0] TRIG_SY   = 5'd4;
    localparam logic [4:0] TRIG_CY   = 5'd5;
    localparam logic [4:0] TRIG_LAST = TRIG_CY;

    localparam logic [1:0] SIN_SQ   = 2'd0;
    localparam logic [1:0] SIN_C    = 2'd1;
    localparam logic [1:0] SIN_B    = 2'd2;
    localparam logic [1:0] SIN_LAST = 2'd3;

    localparam logic [4:0] OP_SPR  = 5'd0;
    localparam logic [4:0] OP_SPC  = 5'd1;
    localparam logic [4:0] OP_R00  = 5'd2;
    localparam logic [4:0] OP_R01A = 5'd3;
    localparam logic [4:0] OP_R01B = 5'd4;
    localparam logic [4:0] OP_R02A = 5'd5;
    localparam logic [4:0] OP_R02B = 5'd6;
    localparam logic [4:0] OP_R10  = 5'd7;
    localparam logic [4:0] OP_R11A = 5'd8;
    localparam logic [4:0] OP_R11B = 5'd9;
    localparam logic [4:0] OP_R12A = 5'd10;
    localparam logic [4:0] OP_R12B = 5'd11;
    localparam logic [4:0] OP_R21  = 5'd12;
    localparam logic [4:0] OP_R22  = 5'd13;
    localparam logic [4:0] OP_DX0  = 5'd14;
    localparam logic [4:0] OP_DX1  = 5'd15;
    localparam logic [4:0] OP_DX2  = 5'd16;
    localparam logic [4:0] OP_DY0  = 5'd17;
    localparam logic [4:0] OP_DY1  = 5'd18;
    localparam logic [4:0] OP_DY2  = 5'd19;
    localparam logic [4:0] OP_DZ0  = 5'd20;
    localparam logic [4:0] OP_DZ1  = 5'd21;
    localparam logic [4:0] OP_DZ2  = 5'd22;
    localparam logic [4:0] OP_N0   = 5'd23;
    localparam logic [4:0] OP_N1   = 5'd24;
    localparam logic [4:0] OP_P0   = 5'd25;
    localparam logic [4:0] OP_P1   = 5'd26;
    localparam logic [4:0] OP_TAN  = 5'd27;
    localparam logic [4:0] OP_LAST = OP_TAN;

    localparam logic [4:0] DIV_YAW = 5'd0;
    localparam logic [4:0] DIV_TAN = 5'd1;

    typedef struct packed {
        logic [3:0] kind;
        logic [4:0] idx;
        logic [1:0] sub;
        logic       phase;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

// ===== rtl/core/rbpi_ctrl.sv =====
// Sequencing controller of the pose integrator.
// Drives the datapath with one command per cycle and owns both handshakes.
// Depends on rbpi_pkg.
module rbpi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    output logic             m_valid,
    input  logic             m_ready,
    output rbpi_pkg::cmd_t   cmd,
    input  rbpi_pkg::status_t status
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOAD = 4'd1;
    localparam logic [3:0] ST_SIN  = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_DIVI = 4'd4;
    localparam logic [3:0] ST_DIVS = 4'd5;
    localparam logic [3:0] ST_DIVD = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_FOLD = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [4:0] idx_reg, idx_next;
    logic [1:0] sub_reg, sub_next;
    logic       phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        sub_next     = sub_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.kind     = rbpi_pkg::CMD_NONE;
        cmd.idx      = idx_reg;
        cmd.sub      = sub_reg;
        cmd.phase    = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.kind = rbpi_pkg::CMD_CAPTURE;
                    if (s_action) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_SIN;
                        idx_next   = rbpi_pkg::TRIG_SR;
                        sub_next   = rbpi_pkg::SIN_SQ;
                        phase_next = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                cmd.kind   = rbpi_pkg::CMD_LOAD;
                state_next = ST_FOLD;
            end
            ST_SIN: begin
                cmd.kind   = rbpi_pkg::CMD_SIN;
                phase_next = ~phase_reg;
                if (phase_reg) begin
                    sub_next = 2'(sub_reg + 2'd1);
                    if (sub_reg == rbpi_pkg::SIN_LAST) begin
                        idx_next = 5'(idx_reg + 5'd1);
                        if (idx_reg == rbpi_pkg::TRIG_LAST) begin
                            state_next = ST_MUL;
                            idx_next   = rbpi_pkg::OP_SPR;
                        end
                    end
                end
            end
            ST_MUL: begin
                cmd.kind   = rbpi_pkg::CMD_MUL;
                phase_next = ~phase_reg;
                if (phase_reg) begin
                    idx_next = 5'(idx_reg + 5'd1);
                    if (idx_reg == rbpi_pkg::OP_LAST) begin
                        state_next = ST_DIVI;
                        idx_next   = rbpi_pkg::DIV_YAW;
                    end
                end
            end
            ST_DIVI: begin
                cmd.kind   = rbpi_pkg::CMD_DIV_INIT;
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                cmd.kind = rbpi_pkg::CMD_DIV_STEP;
                if (status.div_last) begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                cmd.kind = rbpi_pkg::CMD_DIV_DONE;
                if (idx_reg == rbpi_pkg::DIV_YAW) begin
                    idx_next   = rbpi_pkg::DIV_TAN;
                    state_next = ST_DIVI;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.kind   = rbpi_pkg::CMD_UPDATE;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.kind   = rbpi_pkg::CMD_FOLD;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.kind     = rbpi_pkg::CMD_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            sub_reg     <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            sub_reg     <= sub_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_load_folds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |=> (state_reg == ST_FOLD))
        else $error("load did not go on to the pitch fold");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("emitted word not presented on the result channel");

    a_step_starts_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_action)
        |=> (state_reg == ST_SIN && idx_reg == rbpi_pkg::TRIG_SR && !phase_reg))
        else $error("step word did not start the trig sequence");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVS && !status.div_last) |=> (state_reg == ST_DIVS))
        else $error("divider left before its last iteration");

endmodule

// ===== rtl/core/rbpi_datapath.sv =====
// Datapath of the pose integrator: pose state, a shared 18x34 multiplier,
// a radix-2 restoring divider and the output word register.
// Depends on rbpi_pkg; commanded by rbpi_ctrl.
module rbpi_datapath #(
    parameter int POS_BITS   = rbpi_pkg::POS_BITS_DEF,
    parameter int ANGLE_BITS = rbpi_pkg::ANGLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rbpi_pkg::cmd_t           cmd,
    output rbpi_pkg::status_t        status,
    input  logic signed [31:0]       in_lin_x,
    input  logic signed [31:0]       in_lin_y,
    input  logic signed [31:0]       in_lin_z,
    input  logic signed [15:0]       in_ang_x,
    input  logic signed [15:0]       in_ang_y,
    input  logic signed [15:0]       in_ang_z,
    output logic signed [31:0]       out_x,
    output logic signed [31:0]       out_y,
    output logic signed [31:0]       out_z,
    output logic signed [15:0]       out_roll,
    output logic signed [15:0]       out_pitch,
    output logic signed [15:0]       out_yaw,
    output logic                     gimbal_flag
);

    localparam int AB = ANGLE_BITS;
    localparam int MA = 18;
    localparam int MB = 34;
    localparam int MP = MA + MB;
    localparam int SW = 50;
    localparam int DW = rbpi_pkg::DIV_W;

    localparam logic signed [SW-1:0] P_HI = (SW'(1) <<< (POS_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] P_LO = -P_HI - SW'(1);
    localparam logic signed [SW-1:0] O_HI = (SW'(1) <<< 31) - SW'(1);
    localparam logic signed [SW-1:0] O_LO = -O_HI - SW'(1);
    localparam logic signed [MP-1:0] HALF14 = MP'(8192);
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
    localparam logic signed [AB:0] QT_S = (AB + 1)'(1) <<< (AB - 2);
    localparam logic signed [AB:0] HF_S = (AB + 1)'(1) <<< (AB - 1);
    localparam logic [DW-1:0] RMAX = (DW'(1) << (AB - 1)) - DW'(1);

    logic signed [31:0] lx_reg, ly_reg, lz_reg;
    logic signed [15:0] wx_reg, wy_reg, wz_reg;
    logic signed [POS_BITS-1:0] posx_reg, posy_reg, posz_reg;
    logic [AB-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [15:0] trig_reg [6];
    logic [15:0] z2_reg, t_reg;
    logic signed [15:0] spr_reg, spc_reg;
    logic signed [16:0] r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg;
    logic signed [16:0] r21_reg, r22_reg;
    logic signed [MP-1:0] prod_reg, acc_reg;
    logic signed [33:0] n_reg;
    logic [AB-1:0] pr_reg, yr_reg, tr_reg;
    logic [DW-1:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [14:0] dsr_reg;
    logic dsign_reg;
    logic [rbpi_pkg::DIV_CNTW-1:0] div_cnt_reg;
    logic gimbal_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic signed [15:0] oroll_reg, opitch_reg, oyaw_reg;
    logic oflag_reg;

    logic signed [15:0] sr, cr, sp, cp, sy, cy;
    logic [AB-1:0] ang_base, ang;
    logic [1:0] quad;
    logic [AB+12:0] ztmp;
    logic [15:0] zf, z;
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic [16:0] psh15, sin_r;
    logic signed [15:0] sin_val;
    logic signed [MP-1:0] prq, acc_sum, acc_dif, sum_rq, dif_rq, acc_abs;
    logic signed [33:0] n_abs;
    logic gimbal;
    logic [14:0] dv_mag, cp_abs;
    logic [16:0] div_sh;
    logic div_ge;
    logic [DW-1:0] q_sat;
    logic [AB-1:0] q_val;
    logic signed [47:0] wx_ext, wy_ext, wz_ext;
    logic signed [47:0] roll_ext, pitch_ext, yaw_ext;
    logic signed [AB:0] p_s, p_f;
    logic p_flip;

    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > P_HI) ? P_HI : ((v < P_LO) ? P_LO : v);
        return c[POS_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] sat_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > O_HI) ? O_HI : ((v < O_LO) ? O_LO : v);
        return c[31:0];
    endfunction

    assign sr = trig_reg[rbpi_pkg::TRIG_SR[2:0]];
    assign cr = trig_reg[rbpi_pkg::TRIG_CR[2:0]];
    assign sp = trig_reg[rbpi_pkg::TRIG_SP[2:0]];
    assign cp = trig_reg[rbpi_pkg::TRIG_CP[2:0]];
    assign sy = trig_reg[rbpi_pkg::TRIG_SY[2:0]];
    assign cy = trig_reg[rbpi_pkg::TRIG_CY[2:0]];

    always_comb begin
        case (cmd.idx[2:1])
            2'd0:    ang_base = roll_reg;
            2'd1:    ang_base = pitch_reg;
            default: ang_base = yaw_reg;
        endcase
        ang  = cmd.idx[0] ? AB'(ang_base + QUARTER) : ang_base;
        quad = ang[AB-1:AB-2];
        ztmp = {ang[AB-3:0], 15'b0} >> (AB - 2);
        zf   = ztmp[15:0];
        z    = quad[0] ? 16'(17'd32768 - {1'b0, zf}) : zf;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.kind == rbpi_pkg::CMD_SIN) begin
            case (cmd.sub)
                rbpi_pkg::SIN_SQ: begin mul_a = MA'(z);                mul_b = MB'(z);      end
                rbpi_pkg::SIN_C:  begin mul_a = MA'(rbpi_pkg::POLY_C); mul_b = MB'(z2_reg); end
                rbpi_pkg::SIN_B:  begin mul_a = MA'(z2_reg);           mul_b = MB'(t_reg);  end
                default:          begin mul_a = MA'(z);                mul_b = MB'(t_reg);  end
            endcase
        end else begin
            case (cmd.idx)
                rbpi_pkg::OP_SPR:  begin mul_a = MA'(sp);      mul_b = MB'(sr);      end
                rbpi_pkg::OP_SPC:  begin mul_a = MA'(sp);      mul_b = MB'(cr);      end
                rbpi_pkg::OP_R00:  begin mul_a = MA'(cy);      mul_b = MB'(cp);      end
                rbpi_pkg::OP_R01A: begin mul_a = MA'(cy);      mul_b = MB'(spr_reg); end
                rbpi_pkg::OP_R01B: begin mul_a = MA'(sy);      mul_b = MB'(cr);      end
                rbpi_pkg::OP_R02A: begin mul_a = MA'(cy);      mul_b = MB'(spc_reg); end
                rbpi_pkg::OP_R02B: begin mul_a = MA'(sy);      mul_b = MB'(sr);      end
                rbpi_pkg::OP_R10:  begin mul_a = MA'(sy);      mul_b = MB'(cp);      end
                rbpi_pkg::OP_R11A: begin mul_a = MA'(sy);      mul_b = MB'(spr_reg); end
                rbpi_pkg::OP_R11B: begin mul_a = MA'(cy);      mul_b = MB'(cr);      end
                rbpi_pkg::OP_R12A: begin mul_a = MA'(sy);      mul_b = MB'(spc_reg); end
                rbpi_pkg::OP_R12B: begin mul_a = MA'(cy);      mul_b = MB'(sr);      end
                rbpi_pkg::OP_R21:  begin mul_a = MA'(cp);      mul_b = MB'(sr);      end
                rbpi_pkg::OP_R22:  begin mul_a = MA'(cp);      mul_b = MB'(cr);      end
                rbpi_pkg::OP_DX0:  begin mul_a = MA'(r00_reg); mul_b = MB'(lx_reg);  end
                rbpi_pkg::OP_DX1:  begin mul_a = MA'(r01_reg); mul_b = MB'(ly_reg);  end
                rbpi_pkg::OP_DX2:  begin mul_a = MA'(r02_reg); mul_b = MB'(lz_reg);  end
                rbpi_pkg::OP_DY0:  begin mul_a = MA'(r10_reg); mul_b = MB'(lx_reg);  end
                rbpi_pkg::OP_DY1:  begin mul_a = MA'(r11_reg); mul_b = MB'(ly_reg);  end
                rbpi_pkg::OP_DY2:  begin mul_a = MA'(r12_reg); mul_b = MB'(lz_reg);  end
                rbpi_pkg::OP_DZ0:  begin mul_a = -MA'(sp);     mul_b = MB'(lx_reg);  end
                rbpi_pkg::OP_DZ1:  begin mul_a = MA'(r21_reg); mul_b = MB'(ly_reg);  end
                rbpi_pkg::OP_DZ2:  begin mul_a = MA'(r22_reg); mul_b = MB'(lz_reg);  end
                rbpi_pkg::OP_N0:   begin mul_a = MA'(sr);      mul_b = MB'(wy_reg);  end
                rbpi_pkg::OP_N1:   begin mul_a = MA'(cr);      mul_b = MB'(wz_reg);  end
                rbpi_pkg::OP_P0:   begin mul_a = MA'(cr);      mul_b = MB'(wy_reg);  end
                rbpi_pkg::OP_P1:   begin mul_a = MA'(sr);      mul_b = MB'(wz_reg);  end
                rbpi_pkg::OP_TAN:  begin mul_a = MA'(sp);      mul_b = n_reg;        end
                default:           begin mul_a = '0;           mul_b = '0;           end
            endcase
        end
    end

    always_comb begin
        psh15   = prod_reg[31:15];
        sin_r   = 17'(psh15 + 17'd1) >> 1;
        sin_val = quad[1] ? -16'(sin_r) : 16'(sin_r);
        prq     = (prod_reg + HALF14) >>> 14;
        acc_sum = acc_reg + prod_reg;
        acc_dif = acc_reg - prod_reg;
        sum_rq  = (acc_sum + HALF14) >>> 14;
        dif_rq  = (acc_dif + HALF14) >>> 14;
        acc_abs = acc_reg[MP-1] ? -acc_reg : acc_reg;
        n_abs   = n_reg[33] ? -n_reg : n_reg;
        cp_abs  = cp[15] ? 15'(-cp) : cp[14:0];
        gimbal  = (cp < 16'sd64) && (cp > -16'sd64);
        dv_mag  = gimbal ? rbpi_pkg::COS_MIN : cp_abs;
        div_sh  = {rem_reg, dvd_reg[DW-1]};
        div_ge  = (div_sh >= {2'b00, dsr_reg});
        q_sat   = (dvd_reg > RMAX) ? RMAX : dvd_reg;
        q_val   = dsign_reg ? AB'(-q_sat[AB-1:0]) : q_sat[AB-1:0];
        wx_ext  = 48'(wx_reg);
        wy_ext  = 48'(wy_reg);
        wz_ext  = 48'(wz_reg);
        roll_ext  = 48'($signed(roll_reg));
        pitch_ext = 48'($signed(pitch_reg));
        yaw_ext   = 48'($signed(yaw_reg));
        p_s     = $signed({pitch_reg[AB-1], pitch_reg});
        p_flip  = 1'b0;
        p_f     = p_s;
        if (p_s > QT_S) begin
            p_f    = HF_S - p_s;
            p_flip = 1'b1;
        end else if (p_s < -QT_S) begin
            p_f    = -HF_S - p_s;
            p_flip = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (cmd.kind)
            rbpi_pkg::CMD_CAPTURE: begin
                lx_reg <= in_lin_x;
                ly_reg <= in_lin_y;
                lz_reg <= in_lin_z;
                wx_reg <= in_ang_x;
                wy_reg <= in_ang_y;
                wz_reg <= in_ang_z;
            end
            rbpi_pkg::CMD_SIN: begin
                if (cmd.phase) begin
                    case (cmd.sub)
                        rbpi_pkg::SIN_SQ: z2_reg <= psh15[15:0];
                        rbpi_pkg::SIN_C:  t_reg  <= 16'(rbpi_pkg::POLY_B - psh15[15:0]);
                        rbpi_pkg::SIN_B:  t_reg  <= 16'(rbpi_pkg::POLY_A - psh15[15:0]);
                        default:          trig_reg[cmd.idx[2:0]] <= sin_val;
                    endcase
                end
            end
            rbpi_pkg::CMD_MUL: begin
                if (cmd.phase) begin
                    case (cmd.idx)
                        rbpi_pkg::OP_SPR:  spr_reg <= prq[15:0];
                        rbpi_pkg::OP_SPC:  spc_reg <= prq[15:0];
                        rbpi_pkg::OP_R00:  r00_reg <= prq[16:0];
                        rbpi_pkg::OP_R01A: r01_reg <= prq[16:0];
                        rbpi_pkg::OP_R01B: r01_reg <= 17'(r01_reg - prq[16:0]);
                        rbpi_pkg::OP_R02A: r02_reg <= prq[16:0];
                        rbpi_pkg::OP_R02B: r02_reg <= 17'(r02_reg + prq[16:0]);
                        rbpi_pkg::OP_R10:  r10_reg <= prq[16:0];
                        rbpi_pkg::OP_R11A: r11_reg <= prq[16:0];
                        rbpi_pkg::OP_R11B: r11_reg <= 17'(r11_reg + prq[16:0]);
                        rbpi_pkg::OP_R12A: r12_reg <= prq[16:0];
                        rbpi_pkg::OP_R12B: r12_reg <= 17'(r12_reg - prq[16:0]);
                        rbpi_pkg::OP_R21:  r21_reg <= prq[16:0];
                        rbpi_pkg::OP_R22:  r22_reg <= prq[16:0];
                        rbpi_pkg::OP_DX0, rbpi_pkg::OP_DY0, rbpi_pkg::OP_DZ0,
                        rbpi_pkg::OP_P0, rbpi_pkg::OP_TAN: acc_reg <= prod_reg;
                        rbpi_pkg::OP_DX1, rbpi_pkg::OP_DY1, rbpi_pkg::OP_DZ1:
                            acc_reg <= acc_sum;
                        rbpi_pkg::OP_N0:   n_reg <= prod_reg[33:0];
                        rbpi_pkg::OP_N1:   n_reg <= 34'(n_reg + prod_reg[33:0]);
                        rbpi_pkg::OP_P1:   pr_reg <= dif_rq[AB-1:0];
                        default: ;
                    endcase
                end
            end
            rbpi_pkg::CMD_DIV_INIT: begin
                if (cmd.idx == rbpi_pkg::DIV_YAW) begin
                    dvd_reg   <= n_abs[DW-1:0];
                    dsign_reg <= n_reg[33] ^ cp[15];
                end else begin
                    dvd_reg   <= acc_abs[DW+13:14];
                    dsign_reg <= acc_reg[MP-1] ^ cp[15];
                end
                rem_reg <= '0;
                dsr_reg <= dv_mag;
            end
            rbpi_pkg::CMD_DIV_STEP: begin
                rem_reg <= div_ge ? 16'(div_sh - {2'b00, dsr_reg}) : div_sh[15:0];
                dvd_reg <= {dvd_reg[DW-2:0], div_ge};
            end
            rbpi_pkg::CMD_DIV_DONE: begin
                if (cmd.idx == rbpi_pkg::DIV_YAW) begin
                    yr_reg <= q_val;
                end else begin
                    tr_reg <= q_val;
                end
            end
            rbpi_pkg::CMD_EMIT: begin
                ox_reg     <= sat_out(SW'(posx_reg));
                oy_reg     <= sat_out(SW'(posy_reg));
                oz_reg     <= sat_out(SW'(posz_reg));
                oroll_reg  <= roll_ext[15:0];
                opitch_reg <= pitch_ext[15:0];
                oyaw_reg   <= yaw_ext[15:0];
                oflag_reg  <= gimbal_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            posx_reg    <= '0;
            posy_reg    <= '0;
            posz_reg    <= '0;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            gimbal_reg  <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            case (cmd.kind)
                rbpi_pkg::CMD_LOAD: begin
                    posx_reg   <= sat_pos(SW'(lx_reg));
                    posy_reg   <= sat_pos(SW'(ly_reg));
                    posz_reg   <= sat_pos(SW'(lz_reg));
                    roll_reg   <= wx_ext[AB-1:0];
                    pitch_reg  <= wy_ext[AB-1:0];
                    yaw_reg    <= wz_ext[AB-1:0];
                    gimbal_reg <= 1'b0;
                end
                rbpi_pkg::CMD_MUL: begin
                    if (cmd.phase) begin
                        case (cmd.idx)
                            rbpi_pkg::OP_DX2:
                                posx_reg <= sat_pos(SW'(posx_reg) + SW'(sum_rq));
                            rbpi_pkg::OP_DY2:
                                posy_reg <= sat_pos(SW'(posy_reg) + SW'(sum_rq));
                            rbpi_pkg::OP_DZ2:
                                posz_reg <= sat_pos(SW'(posz_reg) + SW'(sum_rq));
                            default: ;
                        endcase
                    end
                end
                rbpi_pkg::CMD_DIV_INIT: div_cnt_reg <= '0;
                rbpi_pkg::CMD_DIV_STEP: div_cnt_reg <= div_cnt_reg + 1'b1;
                rbpi_pkg::CMD_UPDATE: begin
                    roll_reg   <= AB'(roll_reg + wx_ext[AB-1:0] + tr_reg);
                    pitch_reg  <= AB'(pitch_reg + pr_reg);
                    yaw_reg    <= AB'(yaw_reg + yr_reg);
                    gimbal_reg <= gimbal;
                end
                rbpi_pkg::CMD_FOLD: begin
                    pitch_reg <= p_f[AB-1:0];
                    if (p_flip) begin
                        roll_reg[AB-1] <= ~roll_reg[AB-1];
                        yaw_reg[AB-1]  <= ~yaw_reg[AB-1];
                    end
                end
                default: ;
            endcase
        end
    end

    assign status.div_last = (div_cnt_reg == rbpi_pkg::DIV_CNTW'(DW - 1));

    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_z       = oz_reg;
    assign out_roll    = oroll_reg;
    assign out_pitch   = opitch_reg;
    assign out_yaw     = oyaw_reg;
    assign gimbal_flag = oflag_reg;

endmodule

// ===== rtl/core/rigid_body_pose_integrator_unit.sv =====
// Top level of the rigid body pose integrator: controller plus datapath.
// A step word makes 52 passes through the shared multiplier and runs two 32-iteration
// divisions before its result is valid. A load word goes through capture, load, pitch
// fold and emit. A new word is accepted as soon as a result is registered, even while
// that result waits. Synchronous active-low reset zeroes the pose.
module rigid_body_pose_integrator_unit #(
    parameter int POS_BITS   = rbpi_pkg::POS_BITS_DEF,
    parameter int ANGLE_BITS = rbpi_pkg::ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [31:0] s_lin_x,
    input  logic signed [31:0] s_lin_y,
    input  logic signed [31:0] s_lin_z,
    input  logic signed [15:0] s_ang_x,
    input  logic signed [15:0] s_ang_y,
    input  logic signed [15:0] s_ang_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic signed [15:0] m_out_roll,
    output logic signed [15:0] m_out_pitch,
    output logic signed [15:0] m_out_yaw,
    output logic               m_gimbal_flag
);

    rbpi_pkg::cmd_t    cmd;
    rbpi_pkg::status_t status;

    rbpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    rbpi_datapath #(
        .POS_BITS   (POS_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_lin_x    (s_lin_x),
        .in_lin_y    (s_lin_y),
        .in_lin_z    (s_lin_z),
        .in_ang_x    (s_ang_x),
        .in_ang_y    (s_ang_y),
        .in_ang_z    (s_ang_z),
        .out_x       (m_out_x),
        .out_y       (m_out_y),
        .out_z       (m_out_z),
        .out_roll    (m_out_roll),
        .out_pitch   (m_out_pitch),
        .out_yaw     (m_out_yaw),
        .gimbal_flag (m_gimbal_flag)
    );

endmodule

// ===== tb/testbench.sv =====
// Testbench for rigid_body_pose_integrator_unit: directed and random load and step words.
// A scoreboard class predicts each pose result and checks it field by field.
// Depends on rbpi_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_WORDS   = 600;

    typedef struct {
        int      x;
        int      y;
        int      z;
        shortint roll;
        shortint pitch;
        shortint yaw;
        bit      flag;
    } pose_t;

    class PoseTracker;
        longint    px, py, pz;
        bit [15:0] roll, pitch, yaw;
        pose_t     pending[$];
        int        errors;

        function new();
            px = 0; py = 0; pz = 0;
            roll = 0; pitch = 0; yaw = 0;
            errors = 0;
        endfunction

        function longint sin_q14(bit [15:0] a);
            longint z, z2, t, r;
            z = longint'(a[13:0]) << 1;
            if (a[14]) z = 32768 - z;
            z2 = (z * z) >> 15;
            t = longint'(rbpi_pkg::POLY_B) - ((longint'(rbpi_pkg::POLY_C) * z2) >> 15);
            t = longint'(rbpi_pkg::POLY_A) - ((z2 * t) >> 15);
            r = (((z * t) >> 15) + 1) >> 1;
            return a[15] ? -r : r;
        endfunction

        function longint cos_q14(bit [15:0] a);
            return sin_q14(a + 16'd16384);
        endfunction

        function longint round_q14(longint v);
            return (v + 8192) >>> 14;
        endfunction

        function longint sat32(longint v);
            if (v < -64'sd2147483648) return -64'sd2147483648;
            if (v > 64'sd2147483647) return 64'sd2147483647;
            return v;
        endfunction

        function longint clamp_rate(longint v);
            if (v > 32767) return 32767;
            if (v < -32767) return -32767;
            return v;
        endfunction

        function void fold_pitch();
            longint p;
            p = longint'($signed(pitch));
            if (p > 16384 || p < -16384) begin
                p = (p > 0) ? 32768 - p : -32768 - p;
                roll = roll + 16'h8000;
                yaw  = yaw + 16'h8000;
            end
            pitch = 16'(p);
        endfunction

        function void note_word(bit action, int lin_x, int lin_y, int lin_z,
                                shortint ang_x, shortint ang_y, shortint ang_z);
            longint lx, ly, lz, wx, wy, wz;
            longint sr, cr, sp, cp, sy, cy, spr, spc;
            longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
            longint n, dv, yr, tr, pr;
            pose_t  e;
            bit     flag;
            lx = lin_x; ly = lin_y; lz = lin_z;
            wx = ang_x; wy = ang_y; wz = ang_z;
            flag = 0;
            if (action) begin
                px = lx; py = ly; pz = lz;
                roll = 16'(wx); pitch = 16'(wy); yaw = 16'(wz);
            end else begin
                sr = sin_q14(roll);  cr = cos_q14(roll);
                sp = sin_q14(pitch); cp = cos_q14(pitch);
                sy = sin_q14(yaw);   cy = cos_q14(yaw);
                spr = round_q14(sp * sr);
                spc = round_q14(sp * cr);
                r00 = round_q14(cy * cp);
                r01 = round_q14(cy * spr) - round_q14(sy * cr);
                r02 = round_q14(cy * spc) + round_q14(sy * sr);
                r10 = round_q14(sy * cp);
                r11 = round_q14(sy * spr) + round_q14(cy * cr);
                r12 = round_q14(sy * spc) - round_q14(cy * sr);
                r20 = -sp;
                r21 = round_q14(cp * sr);
                r22 = round_q14(cp * cr);
                px = sat32(px + round_q14(r00 * lx + r01 * ly + r02 * lz));
                py = sat32(py + round_q14(r10 * lx + r11 * ly + r12 * lz));
                pz = sat32(pz + round_q14(r20 * lx + r21 * ly + r22 * lz));
                n  = sr * wy + cr * wz;
                dv = cp;
                if (cp < longint'(rbpi_pkg::COS_MIN) && cp > -longint'(rbpi_pkg::COS_MIN)) begin
                    flag = 1;
                    dv = (cp < 0) ? -longint'(rbpi_pkg::COS_MIN) : longint'(rbpi_pkg::COS_MIN);
                end
                yr = clamp_rate(n / dv);
                tr = clamp_rate((sp * n) / (dv * 16384));
                pr = round_q14(cr * wy - sr * wz);
                roll  = 16'(longint'(roll) + wx + tr);
                pitch = 16'(longint'(pitch) + pr);
                yaw   = 16'(longint'(yaw) + yr);
            end
            fold_pitch();
            e.x = int'(px); e.y = int'(py); e.z = int'(pz);
            e.roll = shortint'(roll); e.pitch = shortint'(pitch); e.yaw = shortint'(yaw);
            e.flag = flag;
            pending.push_back(e);
        endfunction

        function void check_word(pose_t got);
            pose_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word x=%0d", $time, got.x);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.x != e.x || got.y != e.y || got.z != e.z || got.roll != e.roll ||
                got.pitch != e.pitch || got.yaw != e.yaw || got.flag != e.flag) begin
                $display("%0t: mismatch expected x=%0d y=%0d z=%0d r=%0d p=%0d w=%0d g=%0b",
                         $time, e.x, e.y, e.z, e.roll, e.pitch, e.yaw, e.flag);
                $display("%0t:          actual x=%0d y=%0d z=%0d r=%0d p=%0d w=%0d g=%0b",
                         $time, got.x, got.y, got.z, got.roll, got.pitch, got.yaw, got.flag);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_action = 0;
    logic signed [31:0] s_lin_x = 0, s_lin_y = 0, s_lin_z = 0;
    logic signed [15:0] s_ang_x = 0, s_ang_y = 0, s_ang_z = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic signed [15:0] m_out_roll, m_out_pitch, m_out_yaw;
    logic        m_gimbal_flag;

    PoseTracker tracker = new();
    bit         steady = 0;
    int         idle_cycles = 0;

    rigid_body_pose_integrator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_lin_x(s_lin_x), .s_lin_y(s_lin_y), .s_lin_z(s_lin_z),
        .s_ang_x(s_ang_x), .s_ang_y(s_ang_y), .s_ang_z(s_ang_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_out_roll(m_out_roll), .m_out_pitch(m_out_pitch), .m_out_yaw(m_out_yaw),
        .m_gimbal_flag(m_gimbal_flag)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(bit action, int lx, int ly, int lz,
                             shortint ax, shortint ay, shortint az);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1;
        s_action = action;
        s_lin_x = lx; s_lin_y = ly; s_lin_z = lz;
        s_ang_x = ax; s_ang_y = ay; s_ang_z = az;
        do @(posedge aclk); while (!s_ready);
        tracker.note_word(action, lx, ly, lz, ax, ay, az);
    endtask

    task automatic send_random_step();
        int lx, ly, lz;
        shortint ax, ay, az;
        if ($urandom_range(0, 9) == 0) begin
            lx = $urandom; ly = $urandom; lz = $urandom;
            ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
        end else begin
            lx = $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
            ly = $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
            lz = $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
            ax = 16'($signed($urandom_range(0, 4000)) - 2000);
            ay = 16'($signed($urandom_range(0, 4000)) - 2000);
            az = 16'($signed($urandom_range(0, 4000)) - 2000);
        end
        send_word(0, lx, ly, lz, ax, ay, az);
    endtask

    task automatic send_random_load();
        shortint p;
        case ($urandom_range(0, 3))
            0: p = 16'(16384 - $urandom_range(0, 40));
            1: p = 16'(-16384 + $urandom_range(0, 40));
            2: p = 16'($urandom);
            default: p = 16'($signed($urandom_range(0, 20000)) - 10000);
        endcase
        send_word(1, $urandom, $urandom, $urandom, 16'($urandom), p, 16'($urandom));
    endtask

    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (steady || $urandom_range(0, 99) < 60) begin
                m_ready = 1;
                repeat ($urandom_range(0, 20)) @(negedge aclk);
            end else begin
                m_ready = 0;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(negedge aclk);
                else repeat ($urandom_range(0, 4)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        pose_t got;
        if (aresetn && m_valid && m_ready) begin
            got.x = m_out_x; got.y = m_out_y; got.z = m_out_z;
            got.roll = m_out_roll; got.pitch = m_out_pitch; got.yaw = m_out_yaw;
            got.flag = m_gimbal_flag;
            tracker.check_word(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed words: extremes, gimbal lock, folding and saturation.
        send_word(0, 32'sh0001_0000, 0, 0, 0, 0, 0);
        send_word(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32767, 32767, 32767);
        send_word(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  -32768, -32768, -32768);
        send_word(1, 32'sh7fff_ffff, 32'sh8000_0000, 0, 16'sh7fff, 16'sh4000, 16'sh8000);
        send_word(0, 32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000, 100, 100, 100);
        send_word(1, 0, 0, 0, 0, -16384, 0);
        send_word(0, 32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000, 500, -500, 300);
        send_word(1, 0, 0, 0, 1000, -32768, 2000);
        send_word(1, 0, 0, 0, 0, 20000, 0);
        send_word(1, 0, 0, 0, 0, -20000, 0);
        send_word(1, 0, 0, 0, 0, 16384 - 2, 0);
        send_word(0, 32'sh0001_0000, 32'sh0001_0000, 0, 32767, 32767, -32768);
        send_word(1, 32'sh7fff_0000, 32'sh7fff_0000, 32'sh8001_0000, 4096, 8192, -8192);
        send_word(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0);
        send_word(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
        send_word(1, -1, -1, -1, -1, -1, -1);
        send_word(0, -1, -1, -1, -1, -1, -1);
        send_word(1, 0, 0, 0, 0, 0, 0);
        send_word(0, 0, 0, 0, 0, 0, 0);

        @(negedge aclk);
        s_valid = 0;
        wait (tracker.pending.size() == 0);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 100 == 0) steady = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_WORDS / 2) begin
                @(negedge aclk);
                s_valid = 0;
                wait (tracker.pending.size() == 0);
            end
            if ($urandom_range(0, 99) < 15) send_random_load();
            else send_random_step();
        end
        steady = 0;

        @(negedge aclk);
        s_valid = 0;
        wait (tracker.pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

// ===== rigid_body_pose_integrator_unit.f =====
rtl/core/rbpi_pkg.sv
rtl/core/rbpi_ctrl.sv
rtl/core/rbpi_datapath.sv
rtl/core/rigid_body_pose_integrator_unit.sv
tb/testbench.sv
